// File: hw/rtl/nearest_point_field_lookup_macros.svh
// Assertion macros shared by the checker file of the lookup block.
`ifndef NEAREST_POINT_FIELD_LOOKUP_MACROS_SVH
`define NEAREST_POINT_FIELD_LOOKUP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define NPFL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define NPFL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/npfl_pkg.sv
// Package with the constants, types and state encoding of the nearest-point field lookup.
package npfl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int COUNT_BITS  = IDX_BITS + 1;
    localparam int COORD_BITS  = 24;
    localparam int FIELD_BITS  = 32;
    localparam int SQ_BITS     = 2 * COORD_BITS;
    localparam int DIST_BITS   = SQ_BITS + 2;
    localparam int AXES        = 3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [FIELD_BITS-1:0] field_t;
    typedef logic [IDX_BITS-1:0]          idx_t;
    typedef logic [COUNT_BITS-1:0]        count_t;
    typedef logic [DIST_BITS-1:0]         dist_t;

    typedef coord_t [AXES-1:0] pos_t;
    typedef field_t [AXES-1:0] fvec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_FINISH
    } npfl_state_t;

    typedef struct packed {
        logic load_we;
        logic start;
        logic issue;
        logic fetch;
        logic finish;
    } npfl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic pipe_busy;
        logic out_free;
    } npfl_status_t;

    typedef struct packed {
        logic  found;
        idx_t  index;
        fvec_t field;
    } npfl_result_t;

    function automatic logic [COORD_BITS-1:0] abs_diff(coord_t a, coord_t b);
        logic [COORD_BITS:0] d;
        logic [COORD_BITS:0] m;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        m = d[COORD_BITS] ? (~d + 1'b1) : d;
        return m[COORD_BITS-1:0];
    endfunction

endpackage

// File: hw/rtl/nearest_point_field_lookup.sv
// Top level of the nearest-point field lookup: port packing, controller and datapath.
//
//   Channel     Direction  Beat contents
//   s_axis      in         load or query item, tuser selects the kind
//   m_axis      out        field, index and found flag of the nearest entry
//   cfg_wr      in         point_count
//
// A load is written to both tables and the block stays ready for the next beat.
// A query over n entries (point_count capped at 1024) runs one position read per
// entry, the end-of-scan step, a drain of the four pipeline stages, the field
// read and the result write; with n zero there are no position reads.
// The result waits in an output register; a stalled consumer holds only the
// end of the next query, and loads are still taken until that query starts.
// Reset clears the count, the controller and the valid flags; table contents stay undefined.
module nearest_point_field_lookup
    import npfl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [10:0]  cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // entry_index, pos_x, pos_y, pos_z, load_bx, load_by, load_bz, zero fill
    input  logic [183:0] s_axis_tdata,
    // cmd
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // field_x, field_y, field_z, nearest_index, zero fill
    output logic [111:0] m_axis_tdata,
    // found
    output logic [0:0]   m_axis_tuser
);

    npfl_cmd_t    cmd;
    npfl_status_t status;
    npfl_result_t result;
    idx_t         in_index;
    pos_t         in_pos;
    fvec_t        in_field;

    assign in_index    = s_axis_tdata[9:0];
    assign in_pos[0]   = s_axis_tdata[33:10];
    assign in_pos[1]   = s_axis_tdata[57:34];
    assign in_pos[2]   = s_axis_tdata[81:58];
    assign in_field[0] = s_axis_tdata[113:82];
    assign in_field[1] = s_axis_tdata[145:114];
    assign in_field[2] = s_axis_tdata[177:146];

    npfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (s_axis_tuser[0]),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    npfl_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_index    (in_index),
        .in_pos      (in_pos),
        .in_field    (in_field),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (result)
    );

    assign m_axis_tdata = {6'b0, result.index, result.field[2], result.field[1], result.field[0]};
    assign m_axis_tuser = result.found;

endmodule

// File: hw/rtl/npfl_ram.sv
// Generic single-write, single-read memory with registered read data.
module npfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/npfl_ctrl.sv
// Controller state machine that sequences loads, the table scan and the result fetch.
module npfl_ctrl
    import npfl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_cmd,
    output logic         in_ready,
    input  npfl_status_t status,
    output npfl_cmd_t    cmd
);

    npfl_state_t state_reg;
    npfl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_cmd == CMD_QUERY)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_we = in_valid && in_cmd == CMD_LOAD;
                cmd.start   = in_valid && in_cmd == CMD_QUERY;
            end
            ST_SCAN:
            begin
                cmd.issue = !status.scan_done;
            end
            ST_DRAIN:
            begin
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: hw/rtl/npfl_datapath.sv
// Datapath with the point tables, the distance pipeline, the running minimum and the result register.
module npfl_datapath
    import npfl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  count_t       cfg_wr_data,
    input  idx_t         in_index,
    input  pos_t         in_pos,
    input  fvec_t        in_field,
    input  npfl_cmd_t    cmd,
    output npfl_status_t status,
    output logic         out_valid,
    input  logic         out_ready,
    output npfl_result_t out_result
);

    count_t count_reg;
    count_t limit_reg;
    count_t addr_reg;
    pos_t   query_reg;

    logic   s0_valid_reg;
    idx_t   s0_idx_reg;
    logic   s1_valid_reg;
    idx_t   s1_idx_reg;
    logic [COORD_BITS-1:0] abs_reg [AXES];
    logic   s2_valid_reg;
    idx_t   s2_idx_reg;
    logic [SQ_BITS-1:0] sq_reg [AXES];
    logic   s3_valid_reg;
    idx_t   s3_idx_reg;
    dist_t  dist_reg;

    logic   found_reg;
    idx_t   best_idx_reg;
    dist_t  best_dist_reg;

    logic         out_valid_reg;
    npfl_result_t out_result_reg;

    pos_t   ram_pos;
    fvec_t  ram_field;
    count_t limit_next;

    npfl_ram #(
        .WIDTH ($bits(pos_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_pos_ram (
        .clk   (clk),
        .we    (cmd.load_we),
        .waddr (in_index),
        .wdata (in_pos),
        .re    (cmd.issue),
        .raddr (addr_reg[IDX_BITS-1:0]),
        .rdata (ram_pos)
    );

    npfl_ram #(
        .WIDTH ($bits(fvec_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_field_ram (
        .clk   (clk),
        .we    (cmd.load_we),
        .waddr (in_index),
        .wdata (in_field),
        .re    (cmd.fetch),
        .raddr (best_idx_reg),
        .rdata (ram_field)
    );

    assign limit_next = (count_reg > count_t'(TABLE_DEPTH)) ? count_t'(TABLE_DEPTH) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            limit_reg     <= '0;
            addr_reg      <= '0;
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
            if (cmd.start)
            begin
                limit_reg <= limit_next;
                addr_reg  <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.issue)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            s0_valid_reg <= cmd.issue;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (s3_valid_reg && (!found_reg || dist_reg < best_dist_reg))
            begin
                found_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            query_reg <= in_pos;
        end
        s0_idx_reg <= addr_reg[IDX_BITS-1:0];
        s1_idx_reg <= s0_idx_reg;
        s2_idx_reg <= s1_idx_reg;
        s3_idx_reg <= s2_idx_reg;
        for (int k = 0; k < AXES; k++)
        begin
            abs_reg[k] <= abs_diff(query_reg[k], ram_pos[k]);
            sq_reg[k]  <= SQ_BITS'(abs_reg[k]) * SQ_BITS'(abs_reg[k]);
        end
        dist_reg <= DIST_BITS'(sq_reg[0]) + DIST_BITS'(sq_reg[1]) + DIST_BITS'(sq_reg[2]);
        if (s3_valid_reg && (!found_reg || dist_reg < best_dist_reg))
        begin
            best_dist_reg <= dist_reg;
            best_idx_reg  <= s3_idx_reg;
        end
        if (cmd.finish)
        begin
            out_result_reg.found <= found_reg;
            out_result_reg.index <= found_reg ? best_idx_reg : '0;
            out_result_reg.field <= found_reg ? ram_field : '0;
        end
    end

    assign status.scan_done = (addr_reg == limit_reg);
    assign status.pipe_busy = s0_valid_reg || s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

// File: hw/rtl/npfl_checker.sv
// Port-level checker for the nearest-point field lookup, bound to the top level.
`include "nearest_point_field_lookup_macros.svh"

module npfl_checker
    import npfl_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [0:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    logic load_beat;
    logic query_beat;

    assign load_beat  = s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == CMD_LOAD;
    assign query_beat = s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == CMD_QUERY;

    `NPFL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result beat dropped while stalled")
    `NPFL_ASSERT_SAME(a_empty_zero, m_axis_tvalid && m_axis_tuser[0] == 1'b0, m_axis_tdata == '0, "empty search returned nonzero data")
    `NPFL_ASSERT_NEXT(a_query_busy, query_beat, !s_axis_tready, "input ready during a query")
    `NPFL_ASSERT_NEXT(a_load_ready, load_beat, s_axis_tready, "input not ready after a load")

endmodule

bind nearest_point_field_lookup npfl_checker u_npfl_checker (.*);
